[hw/rtl/tvd_pkg.sv]
// Package for the TCM Viterbi decoder: command and status codes, sizes,
// and the control and status structs between the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps

package tvd_pkg;

    localparam int MAX_STATES   = 8;
    localparam int MAX_BRANCHES = 4;
    localparam int MAX_POINTS   = 8;
    localparam int MAX_STEPS    = 64;

    localparam int STATE_W = $clog2(MAX_STATES);
    localparam int BRANCH_W = $clog2(MAX_BRANCHES);
    localparam int POINT_W = $clog2(MAX_POINTS);
    localparam int STEP_W = $clog2(MAX_STEPS);
    localparam int METRIC_W = 24;
    localparam int BM_W = 17;
    localparam int RAD_W = 34;

    localparam logic [METRIC_W-1:0] METRIC_MAX = {METRIC_W{1'b1}};

    localparam logic [2:0] CMD_SYMBOL   = 3'd0;
    localparam logic [2:0] CMD_WR_NEXT  = 3'd1;
    localparam logic [2:0] CMD_WR_LABEL = 3'd2;
    localparam logic [2:0] CMD_WR_POINT = 3'd3;
    localparam logic [2:0] CMD_TRACE    = 3'd4;

    localparam logic [2:0] ST_ACCEPTED = 3'd0;
    localparam logic [2:0] ST_DECODED  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_WRITTEN  = 3'd4;

    localparam logic CFG_STATES   = 1'b0;
    localparam logic CFG_BRANCHES = 1'b1;

    typedef struct packed {
        logic       latch;
        logic       do_write;
        logic       bm_init;
        logic       sq_load;
        logic       sqrt_start;
        logic       bm_store;
        logic       acs_clear;
        logic       acs_step;
        logic       surv_write;
        logic       commit;
        logic       clear_all;
        logic       best_init;
        logic       best_step;
        logic       tb_init;
        logic       tb_read;
        logic       tb_use;
        logic       emit_read;
        logic       out_load;
        logic [2:0] out_status;
    } tvd_cmd_t;

    typedef struct packed {
        logic [2:0] command;
        logic       full;
        logic       empty;
        logic       sqrt_done;
        logic       bm_last;
        logic       acs_last;
        logic       surv_last;
        logic       best_done;
        logic       tb_last;
        logic       emit_last;
        logic       out_free;
    } tvd_stat_t;

endpackage

[hw/rtl/tvd_isqrt.sv]
// Iterative integer square root, one result bit per cycle.
// Depends on tvd_pkg for the radicand and root widths.
`timescale 1ns / 1ps

module tvd_isqrt
    import tvd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [RAD_W-1:0] radicand,
    output logic             done,
    output logic [BM_W-1:0]  root
);

    localparam int ITER_W = $clog2(BM_W + 1);
    localparam int REM_W = BM_W + 3;

    logic [RAD_W-1:0]  val_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [BM_W-1:0]   root_reg;
    logic [ITER_W-1:0] iter_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [REM_W-1:0]  rem_shift;
    logic [REM_W-1:0]  trial;

    assign rem_shift = {rem_reg[REM_W-3:0], val_reg[RAD_W-1:RAD_W-2]};
    assign trial = {root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
            val_reg <= '0;
            rem_reg <= '0;
            root_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                iter_reg <= ITER_W'(BM_W);
                val_reg <= radicand;
                rem_reg <= '0;
                root_reg <= '0;
            end
            else if (busy_reg)
            begin
                val_reg <= {val_reg[RAD_W-3:0], 2'b00};
                if (rem_shift >= trial)
                begin
                    rem_reg <= rem_shift - trial;
                    root_reg <= {root_reg[BM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_shift;
                    root_reg <= {root_reg[BM_W-2:0], 1'b0};
                end
                iter_reg <= iter_reg - 1'b1;
                if (iter_reg == ITER_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

[hw/rtl/tvd_datapath.sv]
// Datapath of the TCM Viterbi decoder: tables, branch and path metrics,
// survivor memory, traceback buffer and output register. Uses tvd_pkg and tvd_isqrt.
`timescale 1ns / 1ps

module tvd_datapath
    import tvd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  tvd_cmd_t            cmd,
    output tvd_stat_t           stat,
    input  logic                cfg_write,
    input  logic                cfg_index,
    input  logic [3:0]          cfg_data,
    input  logic [2:0]          command,
    input  logic signed [15:0]  sample_re,
    input  logic signed [15:0]  sample_im,
    input  logic [2:0]          state_index,
    input  logic [1:0]          branch_index,
    input  logic [2:0]          table_value,
    input  logic [2:0]          point_index,
    input  logic signed [15:0]  point_re,
    input  logic signed [15:0]  point_im,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [2:0]          status,
    output logic [1:0]          decoded_input,
    output logic                last
);

    localparam int TAB_W = STATE_W + BRANCH_W;

    logic [3:0] states_reg;
    logic [2:0] branches_reg;
    logic [3:0] ns;
    logic [2:0] nb;

    logic [2:0]         cmd_reg;
    logic signed [15:0] sre_reg;
    logic signed [15:0] sim_reg;
    logic [2:0]         si_reg;
    logic [1:0]         bi_reg;
    logic [2:0]         tv_reg;
    logic [2:0]         pi_reg;
    logic signed [15:0] pre_reg;
    logic signed [15:0] pim_reg;

    logic [STATE_W-1:0]      next_tab [1<<TAB_W];
    logic [POINT_W-1:0]      label_tab [1<<TAB_W];
    logic signed [15:0]      pt_re [MAX_POINTS];
    logic signed [15:0]      pt_im [MAX_POINTS];

    logic [METRIC_W-1:0]     pm_reg [MAX_STATES];
    logic [METRIC_W-1:0]     nm_reg [MAX_STATES];
    logic [MAX_STATES-1:0]   found_reg;
    logic [STATE_W-1:0]      pred_reg [MAX_STATES];
    logic [BRANCH_W-1:0]     inp_reg [MAX_STATES];
    logic [BM_W-1:0]         bm_reg [MAX_POINTS];
    logic [STEP_W:0]         step_reg;

    logic [POINT_W-1:0]      p_reg;
    logic [RAD_W-1:0]        sq_re_reg;
    logic [RAD_W-1:0]        sq_im_reg;
    logic [STATE_W-1:0]      s_reg;
    logic [BRANCH_W-1:0]     b_reg;
    logic [STATE_W-1:0]      t_reg;
    logic [STATE_W:0]        bs_reg;
    logic [STATE_W-1:0]      best_reg;
    logic [STEP_W-1:0]       i_reg;
    logic [STEP_W-1:0]       j_reg;
    logic [STATE_W-1:0]      cur_reg;

    logic [STATE_W+BRANCH_W-1:0] surv_mem [MAX_STEPS*MAX_STATES];
    logic [STATE_W+BRANCH_W-1:0] surv_rd_reg;
    logic [BRANCH_W-1:0]         dec_mem [MAX_STEPS];
    logic [BRANCH_W-1:0]         dec_rd_reg;

    logic                out_valid_reg;
    logic [2:0]          status_reg;
    logic [1:0]          dec_out_reg;
    logic                last_reg;

    logic signed [16:0]  dre;
    logic signed [16:0]  dim;
    logic signed [33:0]  pre_sq;
    logic signed [33:0]  pim_sq;
    logic                sqrt_done;
    logic [BM_W-1:0]     sqrt_root;

    logic [TAB_W-1:0]    tab_idx;
    logic [STATE_W-1:0]  nx;
    logic [POINT_W-1:0]  lab;
    logic [METRIC_W:0]   cost_wide;
    logic [METRIC_W-1:0] cost;
    logic                take;

    assign ns = (states_reg == 4'd0) ? 4'd1 :
                (states_reg > 4'(MAX_STATES)) ? 4'(MAX_STATES) : states_reg;
    assign nb = (branches_reg == 3'd0) ? 3'd1 :
                (branches_reg > 3'(MAX_BRANCHES)) ? 3'(MAX_BRANCHES) : branches_reg;

    assign dre = {sre_reg[15], sre_reg} - {pt_re[p_reg][15], pt_re[p_reg]};
    assign dim = {sim_reg[15], sim_reg} - {pt_im[p_reg][15], pt_im[p_reg]};
    assign pre_sq = dre * dre;
    assign pim_sq = dim * dim;

    tvd_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (sq_re_reg + sq_im_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    assign tab_idx = {s_reg, b_reg};
    assign nx = next_tab[tab_idx];
    assign lab = label_tab[tab_idx];
    assign cost_wide = {1'b0, pm_reg[s_reg]} + (METRIC_W+1)'(bm_reg[lab]);
    assign cost = cost_wide[METRIC_W] ? METRIC_MAX : cost_wide[METRIC_W-1:0];
    assign take = ({1'b0, nx} < ns) && (!found_reg[nx] || (cost < nm_reg[nx]));

    assign stat.command = cmd_reg;
    assign stat.full = (step_reg == (STEP_W+1)'(MAX_STEPS));
    assign stat.empty = (step_reg == '0);
    assign stat.sqrt_done = sqrt_done;
    assign stat.bm_last = (p_reg == POINT_W'(MAX_POINTS - 1));
    assign stat.acs_last = ({1'b0, s_reg} == ns - 4'd1) && ({1'b0, b_reg} == nb - 3'd1);
    assign stat.surv_last = (t_reg == STATE_W'(MAX_STATES - 1));
    assign stat.best_done = ({1'b0, bs_reg} >= {{(4-STATE_W){1'b0}}, ns});
    assign stat.tb_last = (i_reg == '0);
    assign stat.emit_last = ({1'b0, j_reg} == step_reg - 1'b1);
    assign stat.out_free = !out_valid_reg || !out_stall;

    // Tables, item fields, squared distances and branch metrics.
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            cmd_reg <= command;
            sre_reg <= sample_re;
            sim_reg <= sample_im;
            si_reg <= state_index;
            bi_reg <= branch_index;
            tv_reg <= table_value;
            pi_reg <= point_index;
            pre_reg <= point_re;
            pim_reg <= point_im;
        end
        if (cmd.do_write)
        begin
            if (cmd_reg == CMD_WR_NEXT)
                next_tab[{si_reg, bi_reg}] <= tv_reg;
            else if (cmd_reg == CMD_WR_LABEL)
                label_tab[{si_reg, bi_reg}] <= tv_reg;
            else if (cmd_reg == CMD_WR_POINT)
            begin
                pt_re[pi_reg] <= pre_reg;
                pt_im[pi_reg] <= pim_reg;
            end
        end
        if (cmd.sq_load)
        begin
            sq_re_reg <= RAD_W'(unsigned'(pre_sq));
            sq_im_reg <= RAD_W'(unsigned'(pim_sq));
        end
        if (cmd.bm_store)
            bm_reg[p_reg] <= sqrt_root;
    end

    // Survivor memory and traceback buffer.
    always_ff @(posedge clk)
    begin
        if (cmd.surv_write)
            surv_mem[{step_reg[STEP_W-1:0], t_reg}] <= {pred_reg[t_reg], inp_reg[t_reg]};
        if (cmd.tb_read)
            surv_rd_reg <= surv_mem[{i_reg, cur_reg}];
        if (cmd.tb_use)
            dec_mem[i_reg] <= surv_rd_reg[BRANCH_W-1:0];
        if (cmd.emit_read)
            dec_rd_reg <= dec_mem[j_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            states_reg <= 4'(MAX_STATES);
            branches_reg <= 3'(MAX_BRANCHES);
            for (int k = 0; k < MAX_STATES; k++)
            begin
                pm_reg[k] <= '0;
                nm_reg[k] <= METRIC_MAX;
                pred_reg[k] <= '0;
                inp_reg[k] <= '0;
            end
            found_reg <= '0;
            step_reg <= '0;
            p_reg <= '0;
            s_reg <= '0;
            b_reg <= '0;
            t_reg <= '0;
            bs_reg <= '0;
            best_reg <= '0;
            i_reg <= '0;
            j_reg <= '0;
            cur_reg <= '0;
            out_valid_reg <= 1'b0;
            status_reg <= '0;
            dec_out_reg <= '0;
            last_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == CFG_STATES)
                    states_reg <= cfg_data;
                else
                    branches_reg <= cfg_data[2:0];
            end

            if (cmd.bm_init)
                p_reg <= '0;
            else if (cmd.bm_store)
                p_reg <= p_reg + 1'b1;

            if (cmd.acs_clear)
            begin
                for (int k = 0; k < MAX_STATES; k++)
                begin
                    nm_reg[k] <= METRIC_MAX;
                    pred_reg[k] <= '0;
                    inp_reg[k] <= '0;
                end
                found_reg <= '0;
                s_reg <= '0;
                b_reg <= '0;
                t_reg <= '0;
            end
            else if (cmd.acs_step)
            begin
                if (take)
                begin
                    found_reg[nx] <= 1'b1;
                    nm_reg[nx] <= cost;
                    pred_reg[nx] <= s_reg;
                    inp_reg[nx] <= b_reg;
                end
                if ({1'b0, b_reg} == nb - 3'd1)
                begin
                    b_reg <= '0;
                    s_reg <= s_reg + 1'b1;
                end
                else
                    b_reg <= b_reg + 1'b1;
            end
            else if (cmd.surv_write)
                t_reg <= t_reg + 1'b1;

            if (cmd.commit)
            begin
                for (int k = 0; k < MAX_STATES; k++)
                    pm_reg[k] <= nm_reg[k];
                step_reg <= step_reg + 1'b1;
            end
            else if (cmd.clear_all)
            begin
                for (int k = 0; k < MAX_STATES; k++)
                    pm_reg[k] <= '0;
                step_reg <= '0;
            end

            if (cmd.best_init)
            begin
                best_reg <= '0;
                bs_reg <= (STATE_W+1)'(1);
            end
            else if (cmd.best_step)
            begin
                if (pm_reg[bs_reg[STATE_W-1:0]] < pm_reg[best_reg])
                    best_reg <= bs_reg[STATE_W-1:0];
                bs_reg <= bs_reg + 1'b1;
            end

            if (cmd.tb_init)
            begin
                i_reg <= STEP_W'(step_reg - 1'b1);
                cur_reg <= best_reg;
                j_reg <= '0;
            end
            else if (cmd.tb_use)
            begin
                cur_reg <= surv_rd_reg[STATE_W+BRANCH_W-1:BRANCH_W];
                i_reg <= i_reg - 1'b1;
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
                status_reg <= cmd.out_status;
                if (cmd.out_status == ST_DECODED)
                begin
                    dec_out_reg <= dec_rd_reg;
                    last_reg <= stat.emit_last;
                    j_reg <= j_reg + 1'b1;
                end
                else
                begin
                    dec_out_reg <= '0;
                    last_reg <= 1'b1;
                end
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign decoded_input = dec_out_reg;
    assign last = last_reg;

endmodule

[hw/rtl/tvd_ctrl.sv]
// Controller of the TCM Viterbi decoder: sequences table writes, metric
// computation, add-compare-select, traceback and result words. Uses tvd_pkg.
`timescale 1ns / 1ps

module tvd_ctrl
    import tvd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output tvd_cmd_t  cmd,
    input  tvd_stat_t stat
);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_RESP, S_SQ, S_SQRT_GO, S_SQRT_WAIT, S_ACS_INIT, S_ACS,
        S_SURV, S_BEST, S_TB_RD, S_TB_USE, S_EM_RD, S_EM_OUT
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [2:0] resp_reg;
    logic [2:0] resp_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            resp_reg <= ST_ACCEPTED;
        end
        else
        begin
            state_reg <= state_next;
            resp_reg <= resp_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        resp_next = resp_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.command)
                    CMD_SYMBOL:
                    begin
                        if (stat.full)
                        begin
                            resp_next = ST_FULL;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            cmd.bm_init = 1'b1;
                            state_next = S_SQ;
                        end
                    end
                    CMD_WR_NEXT, CMD_WR_LABEL, CMD_WR_POINT:
                    begin
                        cmd.do_write = 1'b1;
                        resp_next = ST_WRITTEN;
                        state_next = S_RESP;
                    end
                    CMD_TRACE:
                    begin
                        if (stat.empty)
                        begin
                            cmd.clear_all = 1'b1;
                            resp_next = ST_EMPTY;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            cmd.best_init = 1'b1;
                            state_next = S_BEST;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_status = resp_reg;
                    state_next = S_IDLE;
                end
            end
            S_SQ:
            begin
                cmd.sq_load = 1'b1;
                state_next = S_SQRT_GO;
            end
            S_SQRT_GO:
            begin
                cmd.sqrt_start = 1'b1;
                state_next = S_SQRT_WAIT;
            end
            S_SQRT_WAIT:
            begin
                if (stat.sqrt_done)
                begin
                    cmd.bm_store = 1'b1;
                    state_next = stat.bm_last ? S_ACS_INIT : S_SQ;
                end
            end
            S_ACS_INIT:
            begin
                cmd.acs_clear = 1'b1;
                state_next = S_ACS;
            end
            S_ACS:
            begin
                cmd.acs_step = 1'b1;
                if (stat.acs_last)
                    state_next = S_SURV;
            end
            S_SURV:
            begin
                cmd.surv_write = 1'b1;
                if (stat.surv_last)
                begin
                    cmd.commit = 1'b1;
                    resp_next = ST_ACCEPTED;
                    state_next = S_RESP;
                end
            end
            S_BEST:
            begin
                if (stat.best_done)
                begin
                    cmd.tb_init = 1'b1;
                    state_next = S_TB_RD;
                end
                else
                    cmd.best_step = 1'b1;
            end
            S_TB_RD:
            begin
                cmd.tb_read = 1'b1;
                state_next = S_TB_USE;
            end
            S_TB_USE:
            begin
                cmd.tb_use = 1'b1;
                state_next = stat.tb_last ? S_EM_RD : S_TB_RD;
            end
            S_EM_RD:
            begin
                cmd.emit_read = 1'b1;
                state_next = S_EM_OUT;
            end
            S_EM_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_status = ST_DECODED;
                    if (stat.emit_last)
                    begin
                        cmd.clear_all = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                        state_next = S_EM_RD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

[hw/rtl/tcm_viterbi_decoder.sv]
// Soft-decision Viterbi decoder for trellis coded modulation, top level.
// For a symbol word, each of the 8 branch metrics goes through the one square
// root unit, then add-compare-select visits one branch per cycle and the 8
// survivors are written one per cycle into a single-port survivor memory.
// A traceback searches the states for the best metric, walks back through registered
// survivor memory reads into the result buffer, then reads it out in order.
// Depends on tvd_pkg, tvd_ctrl, tvd_datapath and tvd_isqrt.
`timescale 1ns / 1ps

module tcm_viterbi_decoder
    import tvd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic               cfg_index,
    input  logic [3:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         command,
    input  logic signed [15:0] sample_re,
    input  logic signed [15:0] sample_im,
    input  logic [2:0]         state_index,
    input  logic [1:0]         branch_index,
    input  logic [2:0]         table_value,
    input  logic [2:0]         point_index,
    input  logic signed [15:0] point_re,
    input  logic signed [15:0] point_im,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         status,
    output logic [1:0]         decoded_input,
    output logic               last
);

    tvd_cmd_t  cmd;
    tvd_stat_t stat;

    tvd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .stat     (stat)
    );

    tvd_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .command       (command),
        .sample_re     (sample_re),
        .sample_im     (sample_im),
        .state_index   (state_index),
        .branch_index  (branch_index),
        .table_value   (table_value),
        .point_index   (point_index),
        .point_re      (point_re),
        .point_im      (point_im),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .decoded_input (decoded_input),
        .last          (last)
    );

endmodule

[verif/tb.sv]
// Self-checking testbench for tcm_viterbi_decoder: a driver feeds command words
// from a queue, a monitor checks every result against a behavioral decoder model.
// Depends on tvd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb;
    import tvd_pkg::*;

    typedef struct {
        logic [2:0]         command;
        logic signed [15:0] sample_re;
        logic signed [15:0] sample_im;
        logic [2:0]         state_index;
        logic [1:0]         branch_index;
        logic [2:0]         table_value;
        logic [2:0]         point_index;
        logic signed [15:0] point_re;
        logic signed [15:0] point_im;
    } word_t;

    typedef struct {
        logic [2:0] status;
        logic [1:0] decoded_input;
        logic       last;
    } result_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic               cfg_index;
    logic [3:0]         cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         command;
    logic signed [15:0] sample_re;
    logic signed [15:0] sample_im;
    logic [2:0]         state_index;
    logic [1:0]         branch_index;
    logic [2:0]         table_value;
    logic [2:0]         point_index;
    logic signed [15:0] point_re;
    logic signed [15:0] point_im;
    logic               out_valid;
    logic               out_stall;
    logic [2:0]         status;
    logic [1:0]         decoded_input;
    logic               last;

    tcm_viterbi_decoder dut (.*);

    word_t   pending_words[$];
    result_t expected_results[$];
    int      error_count;
    int      idle_cycles;
    bit      calm;
    bit      driving_done;

    logic [23:0] trellis_metric[MAX_STATES];
    logic [2:0]  surv_from[MAX_STEPS][MAX_STATES];
    logic [1:0]  surv_branch[MAX_STEPS][MAX_STATES];
    logic [2:0]  next_tab[MAX_STATES][MAX_BRANCHES];
    logic [2:0]  label_tab[MAX_STATES][MAX_BRANCHES];
    logic signed [15:0] pt_re[MAX_POINTS];
    logic signed [15:0] pt_im[MAX_POINTS];
    logic signed [15:0] pt_re_shadow[MAX_POINTS];
    logic signed [15:0] pt_im_shadow[MAX_POINTS];
    int          steps_held;
    logic [3:0]  states_reg;
    logic [2:0]  branches_reg;

    function automatic int active_states();
        if (states_reg < 1)
            return 1;
        return states_reg > MAX_STATES ? MAX_STATES : int'(states_reg);
    endfunction

    function automatic int active_branches();
        if (branches_reg < 1)
            return 1;
        return branches_reg > MAX_BRANCHES ? MAX_BRANCHES : int'(branches_reg);
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned distance(logic signed [15:0] sre,
                                                 logic signed [15:0] sim,
                                                 logic [2:0] lab);
        longint dx;
        longint dy;
        dx = longint'(sre) - longint'(pt_re[lab]);
        dy = longint'(sim) - longint'(pt_im[lab]);
        return root_floor(64'(dx * dx + dy * dy));
    endfunction

    function automatic void push_result(logic [2:0] st, logic [1:0] d, logic l);
        result_t r;
        r.status = st;
        r.decoded_input = d;
        r.last = l;
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic void add_word(word_t w);
        pending_words.insert(pending_words.size(), w);
    endfunction

    function automatic void decode_word(word_t w);
        int ns;
        int nb;
        int best;
        int s;
        logic [23:0] nm[MAX_STATES];
        bit found[MAX_STATES];
        logic [1:0] dec[MAX_STEPS];
        longint unsigned cost;
        ns = active_states();
        nb = active_branches();
        case (w.command)
            CMD_SYMBOL:
            begin
                if (steps_held >= MAX_STEPS)
                begin
                    push_result(ST_FULL, 2'd0, 1'b1);
                    return;
                end
                for (int t = 0; t < MAX_STATES; t++)
                begin
                    nm[t] = METRIC_MAX;
                    found[t] = 0;
                    surv_from[steps_held][t] = '0;
                    surv_branch[steps_held][t] = '0;
                end
                for (int a = 0; a < ns; a++)
                    for (int b = 0; b < nb; b++)
                    begin
                        int nx;
                        nx = int'(next_tab[a][b]);
                        if (nx < ns)
                        begin
                            cost = distance(w.sample_re, w.sample_im, label_tab[a][b])
                                   + 64'(trellis_metric[a]);
                            if (cost > 64'(METRIC_MAX))
                                cost = 64'(METRIC_MAX);
                            if (!found[nx] || cost < 64'(nm[nx]))
                            begin
                                found[nx] = 1;
                                nm[nx] = cost[23:0];
                                surv_from[steps_held][nx] = 3'(a);
                                surv_branch[steps_held][nx] = 2'(b);
                            end
                        end
                    end
                trellis_metric = nm;
                steps_held++;
                push_result(ST_ACCEPTED, 2'd0, 1'b1);
            end
            CMD_WR_NEXT:
            begin
                next_tab[w.state_index][w.branch_index] = w.table_value;
                push_result(ST_WRITTEN, 2'd0, 1'b1);
            end
            CMD_WR_LABEL:
            begin
                label_tab[w.state_index][w.branch_index] = w.table_value;
                push_result(ST_WRITTEN, 2'd0, 1'b1);
            end
            CMD_WR_POINT:
            begin
                pt_re[w.point_index] = w.point_re;
                pt_im[w.point_index] = w.point_im;
                push_result(ST_WRITTEN, 2'd0, 1'b1);
            end
            CMD_TRACE:
            begin
                if (steps_held == 0)
                    push_result(ST_EMPTY, 2'd0, 1'b1);
                else
                begin
                    best = 0;
                    for (int t = 1; t < ns; t++)
                        if (trellis_metric[t] < trellis_metric[best])
                            best = t;
                    s = best;
                    for (int i = steps_held - 1; i >= 0; i--)
                    begin
                        dec[i] = surv_branch[i][s];
                        s = int'(surv_from[i][s]);
                    end
                    for (int i = 0; i < steps_held; i++)
                        push_result(ST_DECODED, dec[i], i == steps_held - 1);
                end
                steps_held = 0;
                for (int t = 0; t < MAX_STATES; t++)
                    trellis_metric[t] = '0;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic word_t blank_word(logic [2:0] c);
        word_t w;
        w.command = c;
        w.sample_re = 16'($urandom);
        w.sample_im = 16'($urandom);
        w.state_index = 3'($urandom);
        w.branch_index = 2'($urandom);
        w.table_value = 3'($urandom);
        w.point_index = 3'($urandom);
        w.point_re = 16'($urandom);
        w.point_im = 16'($urandom);
        return w;
    endfunction

    function automatic void queue_table(logic [2:0] c, int s, int b, int v);
        word_t w;
        w = blank_word(c);
        w.state_index = 3'(s);
        w.branch_index = 2'(b);
        w.table_value = 3'(v);
        add_word(w);
    endfunction

    function automatic void queue_point(int p, logic signed [15:0] re,
                                        logic signed [15:0] im);
        word_t w;
        w = blank_word(CMD_WR_POINT);
        w.point_index = 3'(p);
        w.point_re = re;
        w.point_im = im;
        add_word(w);
    endfunction

    function automatic void queue_symbol(logic signed [15:0] re, logic signed [15:0] im);
        word_t w;
        w = blank_word(CMD_SYMBOL);
        w.sample_re = re;
        w.sample_im = im;
        add_word(w);
    endfunction

    function automatic void queue_random_symbol();
        int p;
        p = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0)
            queue_symbol(16'($urandom), 16'($urandom));
        else
            queue_symbol(pt_re_shadow[p] + $signed(16'($urandom_range(0, 4000)) - 16'sd2000),
                         pt_im_shadow[p] + $signed(16'($urandom_range(0, 4000)) - 16'sd2000));
    endfunction

    function automatic void load_all_tables(bit extreme);
        for (int s = 0; s < MAX_STATES; s++)
            for (int b = 0; b < MAX_BRANCHES; b++)
            begin
                queue_table(CMD_WR_NEXT, s, b, $urandom_range(0, 7));
                queue_table(CMD_WR_LABEL, s, b, $urandom_range(0, 7));
            end
        for (int p = 0; p < MAX_POINTS; p++)
        begin
            if (extreme)
            begin
                pt_re_shadow[p] = p[0] ? 16'sh7fff : 16'sh8000;
                pt_im_shadow[p] = p[1] ? 16'sh7fff : 16'sh8000;
            end
            else
            begin
                pt_re_shadow[p] = 16'($urandom);
                pt_im_shadow[p] = 16'($urandom);
            end
            queue_point(p, pt_re_shadow[p], pt_im_shadow[p]);
        end
    endfunction

    task automatic drain_and_configure(int states, int branches);
        wait (pending_words.size() == 0 && expected_results.size() == 0 && !in_valid);
        repeat (300) @(posedge clk);
        @(posedge clk);
        cfg_write <= 1;
        cfg_index <= CFG_STATES;
        cfg_data <= 4'(states);
        @(posedge clk);
        cfg_index <= CFG_BRANCHES;
        cfg_data <= 4'(branches);
        @(posedge clk);
        cfg_write <= 0;
        states_reg = 4'(states);
        branches_reg = 3'(branches);
    endtask

    task automatic run_phase(int states, int branches, int symbols, bit reload,
                             bit extreme);
        int run;
        drain_and_configure(states, branches);
        if (reload)
            load_all_tables(extreme);
        run = 0;
        for (int i = 0; i < symbols; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                add_word(blank_word(3'd5 + 3'($urandom_range(0, 2))));
            queue_random_symbol();
            run++;
            if (run >= $urandom_range(3, 20) || i == symbols - 1)
            begin
                add_word(blank_word(CMD_TRACE));
                run = 0;
            end
        end
    endtask

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 0;
        cfg_write = 0;
        cfg_index = 0;
        cfg_data = 0;
        calm = 0;
        driving_done = 0;
        states_reg = 8;
        branches_reg = 4;
        steps_held = 0;
        for (int t = 0; t < MAX_STATES; t++)
            trellis_metric[t] = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;

        // Directed: empty traceback, unknown command, extreme table load, a short traceback, then a full store.
        add_word(blank_word(CMD_TRACE));
        add_word(blank_word(3'd7));
        load_all_tables(1);
        queue_symbol(16'sh7fff, 16'sh7fff);
        queue_symbol(16'sh8000, 16'sh8000);
        queue_symbol(16'sh0000, 16'sh0000);
        add_word(blank_word(CMD_TRACE));
        for (int i = 0; i < MAX_STEPS + 2; i++)
            queue_symbol(16'sh8000, 16'sh7fff);
        add_word(blank_word(CMD_TRACE));

        // Out-of-range register values saturate; zero means one.
        run_phase(0, 0, 10, 0, 0);
        run_phase(15, 7, 15, 1, 1);
        run_phase(1, 1, 10, 0, 0);
        calm = 1;
        run_phase(8, 4, 40, 1, 0);
        calm = 0;
        run_phase(3, 2, 20, 0, 0);
        run_phase(5, 3, 20, 0, 0);
        run_phase(8, 4, 30, 0, 0);

        wait (pending_words.size() == 0 && !in_valid);
        driving_done = 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 0;
            command <= 0;
            sample_re <= 0;
            sample_im <= 0;
            state_index <= 0;
            branch_index <= 0;
            table_value <= 0;
            point_index <= 0;
            point_re <= 0;
            point_im <= 0;
            out_stall <= 0;
        end
        else
        begin
            word_t w;
            out_stall <= !calm && $urandom_range(0, 99) < 22;
            if (!in_valid || !in_stall)
            begin
                if (in_valid)
                    decode_word(pending_words.pop_front());
                if (pending_words.size() != 0 && (calm || $urandom_range(0, 99) >= 22))
                begin
                    w = pending_words[0];
                    in_valid <= 1;
                    command <= w.command;
                    sample_re <= w.sample_re;
                    sample_im <= w.sample_im;
                    state_index <= w.state_index;
                    branch_index <= w.branch_index;
                    table_value <= w.table_value;
                    point_index <= w.point_index;
                    point_re <= w.point_re;
                    point_im <= w.point_im;
                end
                else
                    in_valid <= 0;
            end
        end
    end

    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result status=%0d", status);
                error_count++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (status !== e.status)
                begin
                    $error("status expected %0d actual %0d", e.status, status);
                    error_count++;
                end
                if (decoded_input !== e.decoded_input)
                begin
                    $error("decoded_input expected %0d actual %0d",
                           e.decoded_input, decoded_input);
                    error_count++;
                end
                if (last !== e.last)
                begin
                    $error("last expected %0d actual %0d", e.last, last);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    initial
    begin
        wait (driving_done);
        wait (expected_results.size() == 0);
        repeat (400) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/tvd_pkg.sv
hw/rtl/tvd_isqrt.sv
hw/rtl/tvd_datapath.sv
hw/rtl/tvd_ctrl.sv
hw/rtl/tcm_viterbi_decoder.sv
verif/tb.sv
